@@ hw/rtl/spq_pkg.sv @@
package spq_pkg;

    localparam int CAPACITY      = 16;
    localparam int PRIORITY_BITS = 16;
    localparam int PAYLOAD_BITS  = 32;

    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = PRIORITY_BITS + PAYLOAD_BITS;

    typedef enum logic {
        ACT_ENQ = 1'b0,
        ACT_DEQ = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_DUP   = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH_RD,
        S_SRCH_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INSERT,
        S_HEAD_WAIT,
        S_DONE
    } t_state;

    typedef struct packed {
        t_action     action;
        logic [15:0] priority_in;
        logic [31:0] payload_in;
    } t_in_item;

    typedef struct packed {
        t_status     status;
        logic [31:0] payload_out;
        logic [4:0]  entry_count;
        logic [31:0] head_payload;
        logic        head_valid;
    } t_out_item;

    typedef struct packed {
        logic [PRIORITY_BITS-1:0] prio;
        logic [PAYLOAD_BITS-1:0]  payload;
    } t_entry;

endpackage

@@ hw/rtl/spq_ram.sv @@
module spq_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 48
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/spq_ctrl.sv @@
module spq_ctrl
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_res_valid,
    input  logic      i_res_ready,
    output t_out_item o_res
);

    // Map a logical slot (0 = head) onto a physical ring address.
    function automatic logic [IDX_BITS-1:0] wrap_idx(
        input logic [IDX_BITS-1:0] base,
        input logic [CNT_BITS-1:0] ofs
    );
        logic [CNT_BITS:0] sum;
        sum = (CNT_BITS+1)'(base) + (CNT_BITS+1)'(ofs);
        if (sum >= (CNT_BITS+1)'(CAPACITY)) begin
            sum = sum - (CNT_BITS+1)'(CAPACITY);
        end
        return sum[IDX_BITS-1:0];
    endfunction

    t_state                   r_state,    n_state;
    logic [CNT_BITS-1:0]      r_count,    n_count;
    logic [IDX_BITS-1:0]      r_head,     n_head;
    logic [PAYLOAD_BITS-1:0]  r_head_pay, n_head_pay;
    logic [CNT_BITS-1:0]      r_k,        n_k;
    logic [CNT_BITS-1:0]      r_pos,      n_pos;
    logic [PRIORITY_BITS-1:0] r_prio,     n_prio;
    logic [PAYLOAD_BITS-1:0]  r_pay,      n_pay;
    t_status                  r_status,   n_status;
    logic [PAYLOAD_BITS-1:0]  r_removed,  n_removed;

    logic                     ram_we;
    logic [IDX_BITS-1:0]      ram_waddr;
    t_entry                   ram_wdata;
    logic [IDX_BITS-1:0]      ram_raddr;
    t_entry                   ram_rdata;
    logic                     full;

    spq_ram #(
        .DEPTH (CAPACITY),
        .WIDTH (ENTRY_BITS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign full = (r_count == CNT_BITS'(CAPACITY));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_head  <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_head  <= n_head;
        end
        r_head_pay <= n_head_pay;
        r_k        <= n_k;
        r_pos      <= n_pos;
        r_prio     <= n_prio;
        r_pay      <= n_pay;
        r_status   <= n_status;
        r_removed  <= n_removed;
    end

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_head     = r_head;
        n_head_pay = r_head_pay;
        n_k        = r_k;
        n_pos      = r_pos;
        n_prio     = r_prio;
        n_pay      = r_pay;
        n_status   = r_status;
        n_removed  = r_removed;
        ram_we     = 1'b0;
        ram_waddr  = wrap_idx(r_head, r_k);
        ram_wdata  = ram_rdata;
        ram_raddr  = wrap_idx(r_head, CNT_BITS'(1));
        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_removed = '0;
                    n_prio    = i_in_item.priority_in[PRIORITY_BITS-1:0];
                    n_pay     = i_in_item.payload_in[PAYLOAD_BITS-1:0];
                    n_k       = '0;
                    if (i_in_item.action == ACT_ENQ) begin
                        n_state = S_SRCH_RD;
                    end else if (r_count == '0) begin
                        n_status = ST_EMPTY;
                        n_state  = S_DONE;
                    end else begin
                        // Pop the head; the slot after it is already being read.
                        n_status  = ST_OK;
                        n_removed = r_head_pay;
                        n_head    = wrap_idx(r_head, CNT_BITS'(1));
                        n_count   = r_count - 1'b1;
                        n_state   = (r_count > CNT_BITS'(1)) ? S_HEAD_WAIT : S_DONE;
                    end
                end
            end

            S_HEAD_WAIT: begin
                n_head_pay = ram_rdata.payload;
                n_state    = S_DONE;
            end

            S_SRCH_RD: begin
                ram_raddr = wrap_idx(r_head, r_k);
                if (r_k == r_count) begin
                    n_pos = r_k;
                    if (full) begin
                        n_status = ST_FULL;
                        n_state  = S_DONE;
                    end else begin
                        n_state = (r_k == r_count) ? S_INSERT : S_SHIFT_RD;
                    end
                end else begin
                    n_state = S_SRCH_CMP;
                end
            end

            S_SRCH_CMP: begin
                if (ram_rdata.prio == r_prio) begin
                    n_status = ST_DUP;
                    n_state  = S_DONE;
                end else if (ram_rdata.prio > r_prio) begin
                    n_k     = r_k + 1'b1;
                    n_state = S_SRCH_RD;
                end else if (full) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    // Insert here: move the tail down from the last entry.
                    n_pos   = r_k;
                    n_k     = r_count;
                    n_state = S_SHIFT_RD;
                end
            end

            S_SHIFT_RD: begin
                ram_raddr = wrap_idx(r_head, r_k - 1'b1);
                n_state   = S_SHIFT_WR;
            end

            S_SHIFT_WR: begin
                ram_we    = 1'b1;
                ram_waddr = wrap_idx(r_head, r_k);
                ram_wdata = ram_rdata;
                n_k       = r_k - 1'b1;
                n_state   = ((r_k - 1'b1) == r_pos) ? S_INSERT : S_SHIFT_RD;
            end

            S_INSERT: begin
                ram_we            = 1'b1;
                ram_waddr         = wrap_idx(r_head, r_pos);
                ram_wdata.prio    = r_prio;
                ram_wdata.payload = r_pay;
                n_count           = r_count + 1'b1;
                if (r_pos == '0) begin
                    n_head_pay = r_pay;
                end
                n_status = ST_OK;
                n_state  = S_DONE;
            end

            S_DONE: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_res.status       = r_status;
        o_res.payload_out  = 32'(r_removed);
        o_res.entry_count  = 5'(r_count);
        o_res.head_valid   = (r_count != '0);
        o_res.head_payload = (r_count != '0) ? 32'(r_head_pay) : 32'd0;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_BITS'(CAPACITY))
        else $error("entry count above capacity");

    a_insert_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INSERT) |-> !full)
        else $error("insert into a full store");

    a_shift_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT_RD) |-> (r_k > r_pos))
        else $error("shift index at or below insert position");

    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid && i_in_item.action == ACT_DEQ && r_count != '0)
        |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not drop the count");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && i_res_ready) |=> o_in_ready)
        else $error("controller did not return to idle after result transfer");

endmodule

@@ hw/rtl/sorted_priority_queue.sv @@
// Sorted priority queue with unique priorities, CAPACITY entries.
// Input channel (i_in_valid / o_in_ready / i_in_item): action 0 enqueues
// (priority_in, payload_in), action 1 dequeues the highest-priority entry.
// Output channel (o_out_valid / i_out_ready / o_out_item): one result per
// input transfer with status, the removed payload, the entry count and the
// head entry after the operation (peek and size queries).
//
// Entries live in one synchronous RAM organized as a ring that holds the
// entries in descending priority from a head pointer. The single read port
// sets the timing: an enqueue scans the ring with a read and a compare
// state per entry, then moves the tail down with a read and a write state
// per entry. A dequeue only advances the head and, unless the queue is
// left empty, reads the next head payload. The result is then registered
// in the output register. One operation is in work at a time; the next
// input transfer is taken as soon as the result has moved into the output
// register, even while that register waits on a stall.
//
// Reset (synchronous, active low) empties the queue at once; RAM contents
// are left as they are. A stalled receiver holds the output register and,
// once the next result is ready, the controller waits for it.
module sorted_priority_queue
    import spq_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    logic      res_valid;
    logic      res_ready;
    t_out_item res;

    logic      r_out_valid;
    t_out_item r_out;

    spq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Take a new result whenever the output register is empty or draining.
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid && res_ready) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        // Load the result on a transfer from the controller; hold otherwise.
        if (res_valid && res_ready) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
